### hw/rtl/hbs_pkg.sv
// Shared constants, types and helper functions for the 3x3 height map smoothing block.
// Used by heightmap_box_smoothing_3x3; depends on nothing else.
`timescale 1ns / 1ps

package hbs_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned MeanW    = 16;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned WidthW   = ColW + 1;
  localparam int unsigned OutRowW  = $clog2(MaxHeight);
  localparam int unsigned HeightW  = OutRowW + 1;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned WordW    = 2 * SampleW;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  localparam int unsigned SumW       = 12;
  localparam int unsigned CountW     = 4;
  localparam int unsigned NumW       = SumW + 8;
  localparam int unsigned RecipW     = 20;
  localparam int unsigned RecipShift = 21;
  localparam logic [RecipW-1:0] Recip3 = 20'd699051;
  localparam logic [RecipW-1:0] Recip9 = 20'd233017;

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  typedef struct packed {
    logic [SampleW-1:0] top;
    logic [SampleW-1:0] mid;
    logic [SampleW-1:0] bot;
  } column_t;

  typedef struct packed {
    logic [HeightW-1:0] row;
    logic [ColW-1:0]    col;
  } pos_t;

  typedef struct packed {
    logic [MeanW-1:0] mean;
    logic             last;
  } result_t;

  function automatic logic [WidthW-1:0] sat_width(input logic [WidthW-1:0] v);
    logic [WidthW-1:0] r;
    if (v == '0) begin
      r = WidthW'(1);
    end else if (v > WidthW'(MaxWidth)) begin
      r = WidthW'(MaxWidth);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [HeightW-1:0] sat_height(input logic [HeightW-1:0] v);
    logic [HeightW-1:0] r;
    if (v == '0) begin
      r = HeightW'(1);
    end else if (v > HeightW'(MaxHeight)) begin
      r = HeightW'(MaxHeight);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // next raster position
  function automatic pos_t advance(input pos_t p, input logic [WidthW-1:0] w);
    pos_t r;
    if ({1'b0, p.col} + WidthW'(1) == w) begin
      r.row = p.row + HeightW'(1);
      r.col = '0;
    end else begin
      r.row = p.row;
      r.col = p.col + ColW'(1);
    end
    return r;
  endfunction

endpackage

### hw/rtl/heightmap_box_smoothing_3x3.sv
// 3x3 box mean over a raster of 8-bit height samples, Q8.8 rounded output.
// Throughput 1 beat per cycle while the output queue has room, set by the read-modify-write
// of the two-row line memory.
// Reset clears positions, handshake state and the output queue; frame size resets
// to 1024 x 1024. The line memory needs no clearing pass.
// Depends on hbs_pkg.
`timescale 1ns / 1ps

module heightmap_box_smoothing_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hbs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [hbs_pkg::SampleW-1:0]   sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hbs_pkg::MeanW-1:0]     mean_q8_8_o,
  output logic                          last_of_frame_o
);

  // frame size and positions
  logic [hbs_pkg::WidthW-1:0]  w_q;
  logic [hbs_pkg::HeightW-1:0] h_q;
  hbs_pkg::pos_t               in_q, in_d;
  logic [hbs_pkg::OutRowW-1:0] out_row_q, out_row_d;
  logic [hbs_pkg::ColW-1:0]    out_col_q, out_col_d;
  logic [hbs_pkg::SampleW-1:0] s00_q;

  logic is_sample, complete, out_open, past_first;
  logic step_a, emit_a, skip_a, last_a, acc, fire, cfg_wr, pop;
  hbs_pkg::pos_t pos_a, pos_skip;

  // stage 1: memory read in flight
  logic                        s1_valid_q, s1_emit_q, s1_skip_q, s1_last_q;
  logic [hbs_pkg::SampleW-1:0] s1_sample_q;
  logic [hbs_pkg::ColW-1:0]    s1_addr_q;
  logic [hbs_pkg::OutRowW-1:0] s1_row_q;
  logic [hbs_pkg::ColW-1:0]    s1_col_q;

  logic [hbs_pkg::WordW-1:0] line_mem [hbs_pkg::MaxWidth];
  logic [hbs_pkg::WordW-1:0] rd_word_q, fwd_word_q, cur_word, wr_word;
  logic                      fwd_q;
  hbs_pkg::column_t          new_col, skip_col;

  // stage 2: window
  hbs_pkg::column_t            win_q [3];
  logic                        s2_valid_q, s2_last_q;
  logic [hbs_pkg::OutRowW-1:0] s2_row_q;
  logic [hbs_pkg::ColW-1:0]    s2_col_q;

  logic                       top_ok, bot_ok;
  logic [2:0]                 col_ok;
  logic [hbs_pkg::SumW-1:0]   sum;
  logic [1:0]                 rows_n, cols_n;
  logic [hbs_pkg::CountW-1:0] cnt;
  logic [hbs_pkg::NumW-1:0]   num;

  // stage 3: numerator
  logic                       s3_valid_q, s3_last_q;
  logic [hbs_pkg::NumW-1:0]   s3_num_q;
  logic [hbs_pkg::CountW-1:0] s3_cnt_q;

  logic [1:0]                          pre;
  logic                                use_mul;
  logic [hbs_pkg::RecipW-1:0]          recip;
  logic [hbs_pkg::NumW-1:0]            y;
  logic [hbs_pkg::NumW+hbs_pkg::RecipW-1:0] prod;
  logic [hbs_pkg::MeanW-1:0]           mean;

  // output queue
  hbs_pkg::result_t              fifo_mem [hbs_pkg::FifoDepth];
  logic [hbs_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [hbs_pkg::FifoCntW-1:0]  fifo_cnt_q, pend_q, pend_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  // ---------------------------------------------------------------- accept
  assign is_sample  = !action_i;
  assign complete   = in_q.row >= h_q;
  assign out_open   = {1'b0, out_row_q} < h_q;
  assign past_first = (in_q.row > hbs_pkg::HeightW'(1)) ||
                      (in_q.row == hbs_pkg::HeightW'(1) && in_q.col != '0);
  assign step_a     = is_sample ? !complete : (complete && out_open);
  assign emit_a     = is_sample ? (!complete && past_first) : step_a;
  // one-row frame: the first drain also covers the step that no sample filled
  assign skip_a     = !is_sample && step_a && h_q == hbs_pkg::HeightW'(1) && out_col_q == '0;
  assign last_a     = {1'b0, out_row_q} == h_q - hbs_pkg::HeightW'(1) &&
                      {1'b0, out_col_q} == w_q - hbs_pkg::WidthW'(1);
  assign pos_skip   = hbs_pkg::advance(in_q, w_q);
  assign pos_a      = skip_a ? pos_skip : in_q;

  assign in_ready_o = pend_q < hbs_pkg::FifoCntW'(hbs_pkg::FifoDepth);
  assign acc        = in_valid_i && in_ready_o;
  assign fire       = acc && step_a;
  assign pop        = out_valid_o && out_ready_i;

  always_comb begin
    in_d      = in_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (fire) begin
      in_d = hbs_pkg::advance(pos_a, w_q);
    end
    if (acc && emit_a) begin
      if (last_a) begin
        in_d      = '0;
        out_row_d = '0;
        out_col_d = '0;
      end else if ({1'b0, out_col_q} + hbs_pkg::WidthW'(1) == w_q) begin
        out_col_d = '0;
        out_row_d = out_row_q + hbs_pkg::OutRowW'(1);
      end else begin
        out_col_d = out_col_q + hbs_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= hbs_pkg::WidthW'(hbs_pkg::MaxWidth);
      h_q       <= hbs_pkg::HeightW'(1024);
      in_q      <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        hbs_pkg::RegFrameWidth: begin
          w_q <= hbs_pkg::sat_width(cfg_data_i[hbs_pkg::WidthW-1:0]);
        end
        hbs_pkg::RegFrameHeight: begin
          h_q <= hbs_pkg::sat_height(cfg_data_i[hbs_pkg::HeightW-1:0]);
        end
        default: begin
        end
      endcase
      in_q      <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      in_q      <= in_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_sample && in_q.col == '0) begin
      s00_q <= sample_i;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_emit_q   <= emit_a;
      s1_skip_q   <= skip_a;
      s1_last_q   <= last_a;
      s1_sample_q <= sample_i;
      s1_addr_q   <= pos_a.col;
      s1_row_q    <= out_row_q;
      s1_col_q    <= out_col_q;
    end
  end

  // word holds {row above the incoming one, row two above}
  assign cur_word = fwd_q ? fwd_word_q : rd_word_q;
  assign wr_word  = {s1_sample_q, cur_word[hbs_pkg::WordW-1:hbs_pkg::SampleW]};

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_addr_q] <= wr_word;
    end
    if (fire) begin
      rd_word_q  <= line_mem[pos_a.col];
      fwd_word_q <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (fire) begin
      fwd_q <= s1_valid_q && s1_addr_q == pos_a.col;
    end
  end

  assign new_col.top  = cur_word[hbs_pkg::SampleW-1:0];
  assign new_col.mid  = cur_word[hbs_pkg::WordW-1:hbs_pkg::SampleW];
  assign new_col.bot  = s1_sample_q;
  assign skip_col.top = '0;
  assign skip_col.mid = s00_q;
  assign skip_col.bot = '0;

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win_q[0]  <= win_q[1];
      win_q[1]  <= s1_skip_q ? skip_col : win_q[2];
      win_q[2]  <= new_col;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  assign top_ok    = s2_row_q != '0;
  assign bot_ok    = {1'b0, s2_row_q} != h_q - hbs_pkg::HeightW'(1);
  assign col_ok[0] = s2_col_q != '0;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = {1'b0, s2_col_q} != w_q - hbs_pkg::WidthW'(1);

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (col_ok[i]) begin
        sum = sum + hbs_pkg::SumW'(win_q[i].mid);
        if (top_ok) sum = sum + hbs_pkg::SumW'(win_q[i].top);
        if (bot_ok) sum = sum + hbs_pkg::SumW'(win_q[i].bot);
      end
    end
  end

  assign rows_n = 2'd1 + {1'b0, top_ok} + {1'b0, bot_ok};
  assign cols_n = 2'd1 + {1'b0, col_ok[0]} + {1'b0, col_ok[2]};
  assign cnt    = {2'b00, rows_n} * {2'b00, cols_n};
  assign num    = {sum, 8'h00} + hbs_pkg::NumW'(cnt[hbs_pkg::CountW-1:1]);

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_num_q  <= num;
      s3_cnt_q  <= cnt;
      s3_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  // divide by 1..9 neighbors: shift, then reciprocal multiply for 3, 6 and 9
  always_comb begin
    case (s3_cnt_q)
      4'd2:    begin pre = 2'd1; use_mul = 1'b0; recip = hbs_pkg::Recip3; end
      4'd3:    begin pre = 2'd0; use_mul = 1'b1; recip = hbs_pkg::Recip3; end
      4'd4:    begin pre = 2'd2; use_mul = 1'b0; recip = hbs_pkg::Recip3; end
      4'd6:    begin pre = 2'd1; use_mul = 1'b1; recip = hbs_pkg::Recip3; end
      4'd9:    begin pre = 2'd0; use_mul = 1'b1; recip = hbs_pkg::Recip9; end
      default: begin pre = 2'd0; use_mul = 1'b0; recip = hbs_pkg::Recip3; end
    endcase
  end

  assign y    = s3_num_q >> pre;
  assign prod = {{hbs_pkg::RecipW{1'b0}}, y} * {{hbs_pkg::NumW{1'b0}}, recip};
  assign mean = use_mul ? prod[hbs_pkg::RecipShift+hbs_pkg::MeanW-1:hbs_pkg::RecipShift]
                        : y[hbs_pkg::MeanW-1:0];

  // ---------------------------------------------------------------- output queue
  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      fifo_mem[wr_ptr_q].mean <= mean;
      fifo_mem[wr_ptr_q].last <= s3_last_q;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (acc && emit_a) pend_d = pend_d + hbs_pkg::FifoCntW'(1);
    if (pop)           pend_d = pend_d - hbs_pkg::FifoCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      pend_q     <= '0;
    end else begin
      pend_q <= pend_d;
      if (s3_valid_q) wr_ptr_q <= wr_ptr_q + hbs_pkg::FifoPtrW'(1);
      if (pop)        rd_ptr_q <= rd_ptr_q + hbs_pkg::FifoPtrW'(1);
      if (s3_valid_q && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + hbs_pkg::FifoCntW'(1);
      end else if (pop && !s3_valid_q) begin
        fifo_cnt_q <= fifo_cnt_q - hbs_pkg::FifoCntW'(1);
      end
    end
  end

  assign out_valid_o     = fifo_cnt_q != '0;
  assign mean_q8_8_o     = fifo_mem[rd_ptr_q].mean;
  assign last_of_frame_o = fifo_mem[rd_ptr_q].last;

endmodule
